// ===== rtl/cpvp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpvp_pkg: shared types, constants and helpers for the servo loop
// Fixed-point widths, saturation helpers and the configuration record.
// ----------------------------------------------------------------------------
package cpvp_pkg;

	localparam int unsigned MUL_W = 32;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned STEP_PERIOD_DEF = 1000;
	localparam int unsigned TICK_RATE_DEF = 1000;

	localparam logic [30:0] WMAX = 31'h7FFF_FFFF;
	localparam logic [46:0] DELTA_CAP = 47'h7FFF_FFFF_FFFF;
	localparam logic [63:0] HALF_TURN = 64'h0000_0000_8000_0000;
	localparam logic [MUL_W-1:0] MA_PER_AMP = 32'd1000;

	typedef struct packed {
		logic [31:0] pos_kp;
		logic [31:0] pos_ki;
		logic [31:0] pos_ilim;
		logic [31:0] vel_kp;
		logic [31:0] vel_ki;
		logic [31:0] vel_ilim;
		logic [31:0] vel_lim;
		logic [15:0] cur_lim;
	} cfg_t;

	function automatic logic [30:0] sat_mag(input logic [47:0] m);
		return (m > {17'b0, WMAX}) ? WMAX : m[30:0];
	endfunction

	function automatic logic signed [31:0] with_sign(input logic neg, input logic [30:0] mag);
		logic signed [31:0] v;
		v = $signed({1'b0, mag});
		return neg ? -v : v;
	endfunction

	function automatic logic [30:0] mag_of(input logic signed [31:0] w);
		logic signed [31:0] n;
		n = -w;
		return w[31] ? n[30:0] : w[30:0];
	endfunction

	function automatic logic [30:0] lim_of(input logic [31:0] l);
		return l[31] ? WMAX : l[30:0];
	endfunction

	function automatic logic signed [32:0] add33(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return $signed({a[31], a}) + $signed({b[31], b});
	endfunction

	function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return $signed({a[31], a}) - $signed({b[31], b});
	endfunction

	function automatic logic signed [31:0] clamp33(input logic signed [32:0] x,
			input logic [30:0] l);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		logic signed [32:0] r;
		hi = $signed({2'b0, l});
		lo = -hi;
		if (x > hi) begin
			r = hi;
		end else if (x < lo) begin
			r = lo;
		end else begin
			r = x;
		end
		return r[31:0];
	endfunction

endpackage

// ===== rtl/cascaded_position_velocity_pi.sv =====
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pi: cascaded position and velocity PI servo loop
// Position PI with velocity limit feeding a velocity PI with current limit.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Payload
//  in       in   in_valid / in_stall    encoder_fraction, turn_count
//  out      out  out_valid / out_stall  current_command_ma
//  cfg      in   psel, penable, pready  paddr, pwdata, prdata
//
// The first transfer after reset homes the loop and gives no result.
// Every later transfer steps through the state sequence on one shared 32x32
// multiplier; in_stall holds off a new input until the result reaches the output.
// A finished result waits in its state while the output register is stalled.
// Reset clears the loop state and loads the register defaults; no clearing pass.
module cascaded_position_velocity_pi
	import cpvp_pkg::*;
#(
	parameter int unsigned STEP_PERIOD = STEP_PERIOD_DEF,
	parameter int unsigned TICK_RATE = TICK_RATE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         encoder_fraction,
	input  logic [31:0]         turn_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [16:0]  current_command_ma,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int unsigned TICK_W = (STEP_PERIOD > 1) ? $clog2(STEP_PERIOD) : 1;
	localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(STEP_PERIOD - 1);
	localparam logic [MUL_W-1:0] RATE_K = MUL_W'(TICK_RATE);

	typedef enum logic [3:0] {
		S_IDLE, S_VDIF, S_VMAG, S_PMAG, S_VHI, S_GP, S_GI, S_CV,
		S_VE, S_VI, S_VGI, S_CUR, S_MA, S_LIM, S_OUT
	} state_t;

	state_t state_q;
	cfg_t cfg;

	logic homed_q;
	logic [TICK_W-1:0] tick_q;
	logic [63:0] pos_q;
	logic [63:0] cmd_q;
	logic [63:0] prev_q;
	logic [63:0] d_q;
	logic [46:0] vmag_q;
	logic vneg_q;
	logic [31:0] lo_q;
	logic signed [31:0] pe_q;
	logic signed [31:0] pi_q;
	logic signed [31:0] vi_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] cv_q;
	logic signed [31:0] ve_q;
	logic signed [31:0] t_q;
	logic signed [31:0] cur_q;
	logic signed [16:0] ma_q;
	logic out_valid_q;
	logic signed [16:0] out_q;

	logic [MUL_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_b;
	logic [2*MUL_W-1:0] prod;
	logic [63:0] d_abs;
	logic [46:0] vcap;
	logic [47:0] vtot;
	logic [30:0] prod_w;
	logic [24:0] ma_raw;
	logic [15:0] ma_lim;
	logic in_xfer;
	logic out_free;
	logic [63:0] in_pos;

	cpvp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpvp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign current_command_ma = out_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_pos = {turn_count, encoder_fraction};

	assign d_abs = d_q[63] ? (64'd0 - d_q) : d_q;
	assign vcap = (d_abs > {17'b0, DELTA_CAP}) ? DELTA_CAP : d_abs[46:0];
	assign vtot = {1'b0, prod[30:0], 16'b0} + {16'b0, lo_q};
	assign prod_w = sat_mag(prod[63:16]);
	assign ma_raw = prod[40:16];
	assign ma_lim = (ma_raw > {9'b0, cfg.cur_lim}) ? cfg.cur_lim : ma_raw[15:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PMAG: begin
				mul_a = vmag_q[31:0];
				mul_b = RATE_K;
			end
			S_VHI: begin
				mul_a = {17'b0, vmag_q[46:32]};
				mul_b = RATE_K;
			end
			S_GP: begin
				mul_a = {1'b0, mag_of(pe_q)};
				mul_b = cfg.pos_kp;
			end
			S_GI: begin
				mul_a = {1'b0, mag_of(pi_q)};
				mul_b = cfg.pos_ki;
			end
			S_VI: begin
				mul_a = {1'b0, mag_of(ve_q)};
				mul_b = cfg.vel_kp;
			end
			S_VGI: begin
				mul_a = {1'b0, mag_of(vi_q)};
				mul_b = cfg.vel_ki;
			end
			S_MA: begin
				mul_a = {1'b0, mag_of(cur_q)};
				mul_b = MA_PER_AMP;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			homed_q <= 1'b0;
			tick_q <= '0;
			pos_q <= '0;
			cmd_q <= '0;
			prev_q <= '0;
			d_q <= '0;
			vmag_q <= '0;
			vneg_q <= 1'b0;
			lo_q <= '0;
			pe_q <= '0;
			pi_q <= '0;
			vi_q <= '0;
			vel_q <= '0;
			cv_q <= '0;
			ve_q <= '0;
			t_q <= '0;
			cur_q <= '0;
			ma_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						pos_q <= in_pos;
						tick_q <= (tick_q == TICK_LAST) ? '0 : tick_q + 1'b1;
						if (!homed_q) begin
							homed_q <= 1'b1;
							cmd_q <= in_pos;
							prev_q <= in_pos;
						end else begin
							cmd_q <= cmd_q + ((tick_q == '0) ? HALF_TURN : 64'd0);
							state_q <= S_VDIF;
						end
					end
				end
				S_VDIF: begin
					d_q <= pos_q - prev_q;
					prev_q <= pos_q;
					state_q <= S_VMAG;
				end
				S_VMAG: begin
					vneg_q <= d_q[63];
					vmag_q <= vcap;
					d_q <= cmd_q - pos_q;
					state_q <= S_PMAG;
				end
				S_PMAG: begin
					pe_q <= with_sign(d_q[63], sat_mag(d_abs[63:16]));
					state_q <= S_VHI;
				end
				S_VHI: begin
					lo_q <= prod[47:16];
					pi_q <= clamp33(add33(pi_q, pe_q), lim_of(cfg.pos_ilim));
					state_q <= S_GP;
				end
				S_GP: begin
					vel_q <= with_sign(vneg_q, sat_mag(vtot));
					state_q <= S_GI;
				end
				S_GI: begin
					t_q <= with_sign(pe_q[31], prod_w);
					state_q <= S_CV;
				end
				S_CV: begin
					cv_q <= clamp33(add33(t_q, with_sign(pi_q[31], prod_w)),
						lim_of(cfg.vel_lim));
					state_q <= S_VE;
				end
				S_VE: begin
					ve_q <= clamp33(sub33(cv_q, vel_q), WMAX);
					state_q <= S_VI;
				end
				S_VI: begin
					vi_q <= clamp33(add33(vi_q, ve_q), lim_of(cfg.vel_ilim));
					state_q <= S_VGI;
				end
				S_VGI: begin
					t_q <= with_sign(ve_q[31], prod_w);
					state_q <= S_CUR;
				end
				S_CUR: begin
					cur_q <= clamp33(add33(t_q, with_sign(vi_q[31], prod_w)), WMAX);
					state_q <= S_MA;
				end
				S_MA: begin
					state_q <= S_LIM;
				end
				S_LIM: begin
					ma_q <= cur_q[31] ? -$signed({1'b0, ma_lim}) : $signed({1'b0, ma_lim});
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_q <= ma_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_home_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !homed_q) |=> (state_q == S_IDLE && homed_q))
		else $error("homing transfer did not return to idle");

	a_homed_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && homed_q) |=> (state_q == S_VDIF && in_stall))
		else $error("homed transfer did not start the sequence");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= TICK_LAST)
		else $error("tick counter beyond the step period");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && out_stall) |=> (state_q == S_OUT))
		else $error("result left its state while the output was stalled");
`endif

endmodule

// ===== rtl/cpvp_mul.sv =====
// ----------------------------------------------------------------------------
// cpvp_mul: shared multiplier
// Unsigned 32 by 32 multiply with the product registered.
// ----------------------------------------------------------------------------
module cpvp_mul
	import cpvp_pkg::*;
(
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   p_q
);

	logic [2*MUL_W-1:0] prod;

	assign prod = {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};

	always_ff @(posedge clk) begin
		p_q <= prod;
	end

endmodule

// ===== rtl/cpvp_regs.sv =====
// ----------------------------------------------------------------------------
// cpvp_regs: configuration registers
// APB-style register file holding the loop gains and limits.
// ----------------------------------------------------------------------------
module cpvp_regs
	import cpvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	localparam logic [2:0] REG_POS_KP   = 3'd0;
	localparam logic [2:0] REG_POS_KI   = 3'd1;
	localparam logic [2:0] REG_POS_ILIM = 3'd2;
	localparam logic [2:0] REG_VEL_KP   = 3'd3;
	localparam logic [2:0] REG_VEL_KI   = 3'd4;
	localparam logic [2:0] REG_VEL_ILIM = 3'd5;
	localparam logic [2:0] REG_VEL_LIM  = 3'd6;
	localparam logic [2:0] REG_CUR_LIM  = 3'd7;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign idx = paddr[ADDR_W-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_kp <= 32'd1310720;
			cfg_q.pos_ki <= 32'd0;
			cfg_q.pos_ilim <= 32'd0;
			cfg_q.vel_kp <= 32'd655360;
			cfg_q.vel_ki <= 32'd0;
			cfg_q.vel_ilim <= 32'd0;
			cfg_q.vel_lim <= 32'd131072;
			cfg_q.cur_lim <= 16'd4000;
		end else if (wr_en) begin
			case (idx)
				REG_POS_KP:   cfg_q.pos_kp <= pwdata;
				REG_POS_KI:   cfg_q.pos_ki <= pwdata;
				REG_POS_ILIM: cfg_q.pos_ilim <= pwdata;
				REG_VEL_KP:   cfg_q.vel_kp <= pwdata;
				REG_VEL_KI:   cfg_q.vel_ki <= pwdata;
				REG_VEL_ILIM: cfg_q.vel_ilim <= pwdata;
				REG_VEL_LIM:  cfg_q.vel_lim <= pwdata;
				REG_CUR_LIM:  cfg_q.cur_lim <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_POS_KP:   prdata = cfg_q.pos_kp;
			REG_POS_KI:   prdata = cfg_q.pos_ki;
			REG_POS_ILIM: prdata = cfg_q.pos_ilim;
			REG_VEL_KP:   prdata = cfg_q.vel_kp;
			REG_VEL_KI:   prdata = cfg_q.vel_ki;
			REG_VEL_ILIM: prdata = cfg_q.vel_ilim;
			REG_VEL_LIM:  prdata = cfg_q.vel_lim;
			REG_CUR_LIM:  prdata = {16'b0, cfg_q.cur_lim};
			default:      prdata = 32'b0;
		endcase
	end

endmodule

// ===== verif/cascaded_position_velocity_pi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pi_checker: servo loop scoreboard
// Watches the input, output and register ports of the servo loop, keeps its
// own copy of the loop state and registers, predicts the current command for
// every input transfer after the homing one and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
package cascaded_position_velocity_pi_tb_pkg;

	typedef enum logic [2:0] {
		REG_POS_KP,
		REG_POS_KI,
		REG_POS_ILIM,
		REG_VEL_KP,
		REG_VEL_KI,
		REG_VEL_ILIM,
		REG_VEL_LIM,
		REG_CUR_LIM
	} reg_index_e;

endpackage

module cascaded_position_velocity_pi_checker
	import cpvp_pkg::*;
	import cascaded_position_velocity_pi_tb_pkg::*;
#(
	parameter int unsigned STEP_PERIOD = STEP_PERIOD_DEF,
	parameter int unsigned TICK_RATE = TICK_RATE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [31:0]         encoder_fraction,
	input  logic [31:0]         turn_count,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic signed [16:0]  current_command_ma,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  mismatch_count,
	output int                  pending_results
);

	localparam longint W_LIMIT = 64'sd2147483647;
	localparam logic [63:0] W_LIMIT_MAG = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] STEP_CAP = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] HALF_TURN_STEP = 64'h0000_0000_8000_0000;
	localparam int MAX_REPORTED = 50;

	cfg_t loop_cfg;
	logic homed;
	logic [63:0] command_pos;
	logic [63:0] last_pos;
	longint pos_integ;
	longint vel_integ;
	logic [9:0] tick_count;
	logic signed [16:0] expected_ma_q [$];

	initial begin
		mismatch_count = 0;
		pending_results = 0;
	end

	function automatic longint to_w(input bit neg, input logic [63:0] m);
		logic [63:0] c;
		c = (m > W_LIMIT_MAG) ? W_LIMIT_MAG : m;
		return neg ? -$signed(c) : $signed(c);
	endfunction

	function automatic longint sat_w(input longint v);
		if (v > W_LIMIT) begin
			return W_LIMIT;
		end
		if (v < -W_LIMIT) begin
			return -W_LIMIT;
		end
		return v;
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		logic [63:0] r;
		r = (v < 0) ? -v : v;
		return r;
	endfunction

	function automatic longint clamp_to(input longint v, input logic [31:0] l);
		longint lim;
		lim = l[31] ? W_LIMIT : $signed({32'd0, l});
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	function automatic longint delta_to_w(input logic [63:0] d, input bit scaled);
		logic [63:0] m;
		m = d[63] ? (64'd0 - d) : d;
		if (scaled) begin
			if (m > STEP_CAP) begin
				m = STEP_CAP;
			end
			m = m * TICK_RATE;
		end
		return to_w(d[63], m >> 16);
	endfunction

	function automatic longint gain_mul(input longint w, input logic [31:0] g);
		logic [63:0] p;
		p = magnitude(w) * {32'd0, g};
		return to_w(w < 0, p >> 16);
	endfunction

	function automatic bit predict_servo_tick(input logic [63:0] pos,
			output logic signed [16:0] ma);
		longint pe;
		longint vel;
		longint cmd_vel;
		longint ve;
		longint cur;
		logic [63:0] m;
		logic [63:0] sm;
		bit produced;
		ma = '0;
		produced = 1'b0;
		if (!homed) begin
			homed = 1'b1;
			command_pos = pos;
			last_pos = pos;
		end else begin
			if (tick_count == 10'd0) begin
				command_pos = command_pos + HALF_TURN_STEP;
			end
			vel = delta_to_w(pos - last_pos, 1'b1);
			last_pos = pos;
			pe = delta_to_w(command_pos - pos, 1'b0);
			pos_integ = clamp_to(sat_w(pos_integ + pe), loop_cfg.pos_ilim);
			cmd_vel = sat_w(gain_mul(pe, loop_cfg.pos_kp) + gain_mul(pos_integ, loop_cfg.pos_ki));
			cmd_vel = clamp_to(cmd_vel, loop_cfg.vel_lim);
			ve = sat_w(cmd_vel - vel);
			vel_integ = clamp_to(sat_w(vel_integ + ve), loop_cfg.vel_ilim);
			cur = sat_w(gain_mul(ve, loop_cfg.vel_kp) + gain_mul(vel_integ, loop_cfg.vel_ki));
			m = (magnitude(cur) * 64'd1000) >> 16;
			if (m > {48'd0, loop_cfg.cur_lim}) begin
				m = {48'd0, loop_cfg.cur_lim};
			end
			sm = (cur < 0) ? -m : m;
			ma = sm[16:0];
			produced = 1'b1;
		end
		tick_count = tick_count + 10'd1;
		if (tick_count >= STEP_PERIOD) begin
			tick_count = '0;
		end
		return produced;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTED) begin
			$display("%0t: current command mismatch: %s", $realtime, msg);
		end
		mismatch_count = mismatch_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [16:0] want;
		if (!arst_n) begin
			loop_cfg.pos_kp = 32'd1310720;
			loop_cfg.pos_ki = 32'd0;
			loop_cfg.pos_ilim = 32'd0;
			loop_cfg.vel_kp = 32'd655360;
			loop_cfg.vel_ki = 32'd0;
			loop_cfg.vel_ilim = 32'd0;
			loop_cfg.vel_lim = 32'd131072;
			loop_cfg.cur_lim = 16'd4000;
			homed = 1'b0;
			command_pos = '0;
			last_pos = '0;
			pos_integ = 0;
			vel_integ = 0;
			tick_count = '0;
			expected_ma_q.delete();
			pending_results <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_ma_q.size() == 0) begin
					report_mismatch($sformatf("unexpected transfer %0d", current_command_ma));
				end else begin
					want = expected_ma_q.pop_front();
					if (current_command_ma !== want) begin
						report_mismatch($sformatf("got %0d, expected %0d",
								current_command_ma, want));
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (predict_servo_tick({turn_count, encoder_fraction}, want)) begin
					expected_ma_q.push_back(want);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_index_e'(paddr[ADDR_W-1:2]))
					REG_POS_KP: loop_cfg.pos_kp = pwdata;
					REG_POS_KI: loop_cfg.pos_ki = pwdata;
					REG_POS_ILIM: loop_cfg.pos_ilim = pwdata;
					REG_VEL_KP: loop_cfg.vel_kp = pwdata;
					REG_VEL_KI: loop_cfg.vel_ki = pwdata;
					REG_VEL_ILIM: loop_cfg.vel_ilim = pwdata;
					REG_VEL_LIM: loop_cfg.vel_lim = pwdata;
					REG_CUR_LIM: loop_cfg.cur_lim = pwdata[15:0];
					default: ;
				endcase
			end
			pending_results <= expected_ma_q.size();
		end
	end

endmodule

// ===== verif/cascaded_position_velocity_pi_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pi_tb: servo loop testbench top
// Drives encoder ticks and register writes into the servo loop, first a few
// directed positions at the extremes, then phases of random shaft motion under
// several register settings and idle patterns, and reports the verdict.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_pi_tb;
	import cpvp_pkg::*;
	import cascaded_position_velocity_pi_tb_pkg::*;

	localparam int unsigned STEP_PERIOD = 50;
	localparam int unsigned TICK_RATE = 1000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int DRAIN_CYCLES = 32;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum int {
		SET_NOMINAL,
		SET_MODERATE,
		SET_ALL_ONES,
		SET_ZERO,
		SET_RANDOM,
		SET_LIMIT_EDGE
	} setting_e;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [31:0] encoder_fraction;
	logic [31:0] turn_count;
	logic out_valid;
	logic out_stall;
	logic signed [16:0] current_command_ma;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	int mismatch_count;
	int pending_results;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	logic [63:0] shaft_pos;

	cascaded_position_velocity_pi #(
		.STEP_PERIOD(STEP_PERIOD),
		.TICK_RATE(TICK_RATE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.encoder_fraction(encoder_fraction),
		.turn_count(turn_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.current_command_ma(current_command_ma),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cascaded_position_velocity_pi_checker #(
		.STEP_PERIOD(STEP_PERIOD),
		.TICK_RATE(TICK_RATE)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.encoder_fraction(encoder_fraction),
		.turn_count(turn_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.current_command_ma(current_command_ma),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatch_count(mismatch_count),
		.pending_results(pending_results)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_register(input reg_index_e index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_setting(input setting_e kind);
		cfg_t s;
		s = '0;
		case (kind)
			SET_NOMINAL: begin
				s.pos_kp = 32'h0014_0000;
				s.pos_ki = 32'h0000_8000;
				s.pos_ilim = 32'h0001_0000;
				s.vel_kp = 32'h000A_0000;
				s.vel_ki = 32'h0004_0000;
				s.vel_ilim = 32'h0002_0000;
				s.vel_lim = 32'h0002_0000;
				s.cur_lim = 16'd4000;
			end
			SET_MODERATE: begin
				s.pos_kp = $urandom_range(32'h0040_0000);
				s.pos_ki = $urandom_range(32'h0004_0000);
				s.pos_ilim = $urandom_range(32'h0008_0000);
				s.vel_kp = $urandom_range(32'h0040_0000);
				s.vel_ki = $urandom_range(32'h0010_0000);
				s.vel_ilim = $urandom_range(32'h0008_0000);
				s.vel_lim = $urandom_range(32'h0008_0000);
				s.cur_lim = 16'($urandom);
			end
			SET_ALL_ONES: s = '1;
			SET_ZERO: s = '0;
			SET_RANDOM: s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, 16'($urandom)};
			SET_LIMIT_EDGE: begin
				s.pos_kp = 32'h0014_0000;
				s.pos_ki = 32'h0000_4000;
				s.pos_ilim = 32'h7FFF_FFFF;
				s.vel_kp = 32'h000A_0000;
				s.vel_ki = 32'h0001_0000;
				s.vel_ilim = 32'h8000_0000;
				s.vel_lim = 32'h7FFF_FFFF;
				s.cur_lim = 16'hFFFF;
			end
			default: ;
		endcase
		write_register(REG_POS_KP, s.pos_kp);
		write_register(REG_POS_KI, s.pos_ki);
		write_register(REG_POS_ILIM, s.pos_ilim);
		write_register(REG_VEL_KP, s.vel_kp);
		write_register(REG_VEL_KI, s.vel_ki);
		write_register(REG_VEL_ILIM, s.vel_ilim);
		write_register(REG_VEL_LIM, s.vel_lim);
		write_register(REG_CUR_LIM, {16'($urandom), s.cur_lim});
	endtask

	task automatic send_tick(input logic [31:0] fraction, input logic [31:0] turns);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		encoder_fraction <= fraction;
		turn_count <= turns;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_position(input logic [63:0] pos);
		shaft_pos = pos;
		send_tick(pos[31:0], pos[63:32]);
	endtask

	task automatic send_random_tick();
		int unsigned roll;
		logic [63:0] target;
		logic [63:0] delta;
		roll = $urandom_range(99);
		delta = 64'd0;
		if (roll < 8) begin
			target = {$urandom, $urandom};
		end else begin
			if (roll < 14) begin
				delta = {$urandom, $urandom} >> $urandom_range(40, 20);
			end else if (roll >= 20) begin
				delta = 64'($urandom_range(32'h0200_0000));
			end
			target = $urandom_range(1) ? shaft_pos + delta : shaft_pos - delta;
		end
		send_position(target);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		encoder_fraction = '0;
		turn_count = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		shaft_pos = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Home just below a turn rollover, then cross it both ways.
		send_position(64'hFFFF_FFFF_FFFF_0000);
		send_position(64'h0000_0000_0000_1000);
		send_position(64'hFFFF_FFFF_FFFF_F000);
		send_position(64'h0000_0000_0000_0000);
		send_position(64'h7FFF_FFFF_FFFF_FFFF);
		send_position(64'h8000_0000_0000_0000);
		send_position(64'hFFFF_FFFF_FFFF_FFFF);
		send_position(64'h0000_0000_0000_0000);
		send_position(64'h0000_0000_8000_0000);
		send_position(64'h0000_0000_7FFF_FFFF);
		send_position(64'h0000_0000_7FFF_FFFF);
		send_position(64'h0000_0000_7FC0_0000);
		send_position(64'h0000_0000_7F80_0000);
		send_position(64'h0000_0001_0000_0000);
		send_position(64'h0000_0000_FFFF_FFFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			load_setting(setting_e'(phase % 6));
			case (phase % 4)
				1: begin
					send_idle_pct = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 86;
				end
				3: begin
					send_idle_pct = 13;
					recv_stall_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			repeat (ITEMS_PER_PHASE) send_random_tick();
		end

		drain_results();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cpvp_pkg.sv
rtl/cpvp_mul.sv
rtl/cpvp_regs.sv
rtl/cascaded_position_velocity_pi.sv
verif/cascaded_position_velocity_pi_checker.sv
verif/cascaded_position_velocity_pi_tb.sv
